// ----- design/esc_pkg.sv -----
// ----------------------------------------------------------------------------
// esc_pkg: shared types and constants for the elevator scan controller
// Floor field width, beat kind codes and the car heading encoding.
// ----------------------------------------------------------------------------
package esc_pkg;

  // Floor number field width and the floors it can name
  localparam int FLOOR_W   = 4;
  localparam int FLOOR_CNT = 1 << FLOOR_W;

  // Input beat kind
  localparam logic KIND_TICK = 1'b0;
  localparam logic KIND_REQ  = 1'b1;

  // Car heading
  typedef enum logic [1:0] {
    DIR_IDLE = 2'd0,
    DIR_UP   = 2'd1,
    DIR_DOWN = 2'd2
  } dir_t;

endpackage

// ----- design/esc_in_if.sv -----
// ----------------------------------------------------------------------------
// esc_in_if: request/tick channel
// Valid/ready channel carrying one tick or floor request per beat.
// ----------------------------------------------------------------------------
interface esc_in_if;
  logic                        valid;
  logic                        ready;
  logic                        kind;
  logic [esc_pkg::FLOOR_W-1:0] floor;

  modport source (output valid, kind, floor, input ready);
  modport sink   (input valid, kind, floor, output ready);
endinterface

// ----- design/esc_out_if.sv -----
// ----------------------------------------------------------------------------
// esc_out_if: car status channel
// Valid/ready channel carrying the car status after each input beat.
// ----------------------------------------------------------------------------
interface esc_out_if;
  logic                        valid;
  logic                        ready;
  logic [esc_pkg::FLOOR_W-1:0] car_floor;
  logic [1:0]                  travel_dir;
  logic                        door_opened;
  logic                        pending;

  modport source (output valid, car_floor, travel_dir, door_opened, pending, input ready);
  modport sink   (input valid, car_floor, travel_dir, door_opened, pending, output ready);
endinterface

// ----- design/elevator_scan_controller.sv -----
// ----------------------------------------------------------------------------
// elevator_scan_controller: single-car SCAN elevator scheduler
// Records floor requests in up/down sets and moves the car at most one floor per tick.
// ----------------------------------------------------------------------------
//  Channel   Dir  Payload                                    Beat
//  in_chan   in   kind, floor                                tick or request
//  out_chan  out  car_floor, travel_dir, door_opened, pending status per input
//
//  Request sets, position and heading update at the accepting edge, and the
//  status lands in the output register at that edge. Priority encoders over
//  the two request sets sit on the combinational next-state path.
//  Sync reset (rst_n low) clears both sets, parks the car at floor 0, idle.
//  in_chan.ready is high while the output register is empty or being drained,
//  so a stalled sink holds one status beat and stops the input.
// ----------------------------------------------------------------------------
module elevator_scan_controller #(
  parameter int NUM_FLOORS = 16
) (
  input  logic      clk,
  input  logic      rst_n,
  esc_in_if.sink    in_chan,
  esc_out_if.source out_chan
);

  localparam int FW    = esc_pkg::FLOOR_W;
  localparam int SET_W = (NUM_FLOORS < esc_pkg::FLOOR_CNT) ? NUM_FLOORS : esc_pkg::FLOOR_CNT;

  // State
  logic [SET_W-1:0] up_r, up_nxt;
  logic [SET_W-1:0] down_r, down_nxt;
  logic [FW-1:0]    pos_r, pos_nxt;
  esc_pkg::dir_t    head_r, head_nxt, head_sel;

  // Output register
  logic             out_valid_r;
  logic [FW-1:0]    car_floor_r;
  logic [1:0]       travel_dir_r;
  logic             door_r, door_nxt;
  logic             pending_r;

  logic             in_accept;
  logic             req_in_range;
  logic             up_any, down_any;
  logic [SET_W-1:0] req_mask, up_low_mask, down_high_mask;
  logic [FW-1:0]    up_low, down_high;

  assign in_chan.ready = !out_valid_r || out_chan.ready;
  assign in_accept     = in_chan.valid && in_chan.ready;

  assign up_any       = |up_r;
  assign down_any     = |down_r;
  assign req_in_range = int'(in_chan.floor) < NUM_FLOORS;

  // Request decode and priority encoders over the request sets
  always_comb begin
    up_low         = '0;
    down_high      = '0;
    up_low_mask    = '0;
    down_high_mask = '0;
    for (int i = 0; i < SET_W; i++) begin
      req_mask[i] = (in_chan.floor == FW'(i));
    end
    for (int i = SET_W - 1; i >= 0; i--) begin
      if (up_r[i]) begin
        up_low      = FW'(i);
        up_low_mask = '0;
        up_low_mask[i] = 1'b1;
      end
    end
    for (int i = 0; i < SET_W; i++) begin
      if (down_r[i]) begin
        down_high      = FW'(i);
        down_high_mask = '0;
        down_high_mask[i] = 1'b1;
      end
    end
  end

  // Heading served by a tick: keep a live heading, else prefer up
  always_comb begin
    if (head_r == esc_pkg::DIR_UP || head_r == esc_pkg::DIR_DOWN) begin
      head_sel = head_r;
    end else if (up_any) begin
      head_sel = esc_pkg::DIR_UP;
    end else begin
      head_sel = esc_pkg::DIR_DOWN;
    end
  end

  // Next state for one beat
  always_comb begin
    up_nxt   = up_r;
    down_nxt = down_r;
    pos_nxt  = pos_r;
    head_nxt = head_r;
    door_nxt = 1'b0;
    if (in_chan.kind == esc_pkg::KIND_REQ) begin
      // out-of-range floors are dropped
      if (req_in_range) begin
        if (in_chan.floor == pos_r) begin
          door_nxt = 1'b1;
        end else if (in_chan.floor > pos_r) begin
          up_nxt = up_r | req_mask;
        end else begin
          down_nxt = down_r | req_mask;
        end
      end
    end else if (!up_any && !down_any) begin
      head_nxt = esc_pkg::DIR_IDLE;
    end else if (head_sel == esc_pkg::DIR_UP) begin
      if (up_any) begin
        if (pos_r < up_low) begin
          pos_nxt = pos_r + FW'(1);
        end else if (pos_r == up_low) begin
          door_nxt = 1'b1;
          up_nxt   = up_r & ~up_low_mask;
        end
      end
      if (|up_nxt) begin
        head_nxt = esc_pkg::DIR_UP;
      end else begin
        head_nxt = down_any ? esc_pkg::DIR_DOWN : esc_pkg::DIR_IDLE;
      end
    end else begin
      if (down_any) begin
        if (pos_r > down_high) begin
          pos_nxt = pos_r - FW'(1);
        end else if (pos_r == down_high) begin
          door_nxt = 1'b1;
          down_nxt = down_r & ~down_high_mask;
        end
      end
      if (|down_nxt) begin
        head_nxt = esc_pkg::DIR_DOWN;
      end else begin
        head_nxt = up_any ? esc_pkg::DIR_UP : esc_pkg::DIR_IDLE;
      end
    end
  end

  // State registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      up_r   <= '0;
      down_r <= '0;
      pos_r  <= '0;
      head_r <= esc_pkg::DIR_IDLE;
    end else if (in_accept) begin
      up_r   <= up_nxt;
      down_r <= down_nxt;
      pos_r  <= pos_nxt;
      head_r <= head_nxt;
    end
  end

  // Output valid
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (in_accept) begin
      out_valid_r <= 1'b1;
    end else if (out_chan.ready) begin
      out_valid_r <= 1'b0;
    end
  end

  // Output payload
  always_ff @(posedge clk) begin
    if (in_accept) begin
      car_floor_r  <= pos_nxt;
      travel_dir_r <= head_nxt;
      door_r       <= door_nxt;
      pending_r    <= (|up_nxt) || (|down_nxt);
    end
  end

  assign out_chan.valid       = out_valid_r;
  assign out_chan.car_floor   = car_floor_r;
  assign out_chan.travel_dir  = travel_dir_r;
  assign out_chan.door_opened = door_r;
  assign out_chan.pending     = pending_r;

  // Checks
  a_status_matches_state: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r |-> (car_floor_r == pos_r && pending_r == ((|up_r) || (|down_r))))
    else $error("status beat disagrees with car state");

  a_one_floor_step: assert property (@(posedge clk) disable iff (!rst_n)
    ($past(rst_n) && pos_r != $past(pos_r)) |->
      (pos_r == $past(pos_r) + FW'(1) || pos_r + FW'(1) == $past(pos_r)))
    else $error("car moved more than one floor");

  a_no_door_while_moving: assert property (@(posedge clk) disable iff (!rst_n)
    in_accept |=> (!door_r || pos_r == $past(pos_r)))
    else $error("doors opened on a moving beat");

  a_stall_holds_state: assert property (@(posedge clk) disable iff (!rst_n)
    !in_accept |=> ($stable(up_r) && $stable(down_r) && $stable(pos_r)))
    else $error("car state changed without an input beat");

endmodule

// ----- dv/elevator_scan_controller_tb.sv -----
// ----------------------------------------------------------------------------
// elevator_scan_controller_tb: self-checking bench for the SCAN car scheduler
// Drives ticks and floor requests through the input channel and keeps its own
// model of the request sets, car floor and heading. It checks every status beat
// against that model under random sender bursts, receiver stalls and a long
// output hold-off.
// ----------------------------------------------------------------------------
module elevator_scan_controller_tb;

  localparam int NUM_FLOORS = 16;
  localparam int IDLE_LIMIT = 1000;
  localparam int HOLD_LEN   = 64;

  typedef struct packed {
    logic [esc_pkg::FLOOR_W-1:0] car_floor;
    esc_pkg::dir_t               travel_dir;
    logic                        door_opened;
    logic                        pending;
  } car_status_t;

  logic clk = 1'b0;
  logic rst_n;

  esc_in_if  in_chan ();
  esc_out_if out_chan ();

  elevator_scan_controller #(
    .NUM_FLOORS(NUM_FLOORS)
  ) DUT (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_chan  (in_chan),
    .out_chan (out_chan)
  );

  // Car model state
  logic [esc_pkg::FLOOR_CNT-1:0] up_reqs;
  logic [esc_pkg::FLOOR_CNT-1:0] down_reqs;
  logic [esc_pkg::FLOOR_W-1:0]   car_pos;
  esc_pkg::dir_t                 car_dir;

  car_status_t car_status_due[$];
  int          mismatches = 0;
  int          quiet_cycles = 0;

  // Traffic shaping: steady turns off all idling, hold_off forces a long stall
  bit steady = 1'b0;
  int hold_off = 0;
  int burst_left = 0;
  int rx_ready_left = 0;
  int rx_stall_left = 0;

  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  // Advance the car model by one beat and return the status it produces
  function automatic car_status_t step_car(input logic k,
                                           input logic [esc_pkg::FLOOR_W-1:0] f);
    car_status_t s;
    int          tgt;
    logic        door;
    door = 1'b0;
    if (k == esc_pkg::KIND_REQ) begin
      if (int'(f) < NUM_FLOORS) begin
        if (f == car_pos) begin
          door = 1'b1;
        end else if (f > car_pos) begin
          up_reqs[f] = 1'b1;
        end else begin
          down_reqs[f] = 1'b1;
        end
      end
    end else if (up_reqs == '0 && down_reqs == '0) begin
      car_dir = esc_pkg::DIR_IDLE;
    end else begin
      // Idle car picks up first, down otherwise, then serves in the same tick
      if (car_dir != esc_pkg::DIR_UP && car_dir != esc_pkg::DIR_DOWN) begin
        car_dir = (up_reqs != '0) ? esc_pkg::DIR_UP : esc_pkg::DIR_DOWN;
      end
      if (car_dir == esc_pkg::DIR_UP) begin
        if (up_reqs != '0) begin
          tgt = 0;
          for (int i = esc_pkg::FLOOR_CNT - 1; i >= 0; i--) begin
            if (up_reqs[i]) tgt = i;
          end
          if (int'(car_pos) < tgt) begin
            car_pos = car_pos + 1'b1;
          end else if (int'(car_pos) == tgt) begin
            door = 1'b1;
            up_reqs[esc_pkg::FLOOR_W'(tgt)] = 1'b0;
          end
        end
        if (up_reqs == '0) begin
          car_dir = (down_reqs != '0) ? esc_pkg::DIR_DOWN : esc_pkg::DIR_IDLE;
        end
      end else begin
        if (down_reqs != '0) begin
          tgt = 0;
          for (int i = 0; i < esc_pkg::FLOOR_CNT; i++) begin
            if (down_reqs[i]) tgt = i;
          end
          if (int'(car_pos) > tgt) begin
            car_pos = car_pos - 1'b1;
          end else if (int'(car_pos) == tgt) begin
            door = 1'b1;
            down_reqs[esc_pkg::FLOOR_W'(tgt)] = 1'b0;
          end
        end
        if (down_reqs == '0) begin
          car_dir = (up_reqs != '0) ? esc_pkg::DIR_UP : esc_pkg::DIR_IDLE;
        end
      end
    end
    s.car_floor   = car_pos;
    s.travel_dir  = car_dir;
    s.door_opened = door;
    s.pending     = (up_reqs != '0) || (down_reqs != '0);
    return s;
  endfunction

  task automatic report_mismatch(input string what, input int got, input int want);
    $display("[%0t] status %s: got %0d, want %0d", $time, what, got, want);
    mismatches++;
  endtask

  // Offer one beat from a falling edge; returns at the falling edge after acceptance
  task automatic send_beat(input logic k, input logic [esc_pkg::FLOOR_W-1:0] f);
    if (!steady && burst_left == 0) begin
      in_chan.valid = 1'b0;
      repeat ($urandom_range(1, 6)) @(negedge clk);
      burst_left = $urandom_range(1, 20);
    end
    in_chan.valid = 1'b1;
    in_chan.kind  = k;
    in_chan.floor = f;
    do @(posedge clk); while (!in_chan.ready);
    car_status_due.push_back(step_car(k, f));
    if (burst_left > 0) burst_left--;
    @(negedge clk);
  endtask

  task automatic pause_until_drained();
    in_chan.valid = 1'b0;
    while (car_status_due.size() != 0) @(negedge clk);
  endtask

  // Status beat checker
  always @(posedge clk) begin : check_status
    car_status_t want;
    if (rst_n && out_chan.valid && out_chan.ready) begin
      if (car_status_due.size() == 0) begin
        report_mismatch("beat with nothing due, car_floor", int'(out_chan.car_floor), 0);
      end else begin
        want = car_status_due.pop_front();
        if (out_chan.car_floor !== want.car_floor)
          report_mismatch("car_floor", int'(out_chan.car_floor), int'(want.car_floor));
        if (out_chan.travel_dir !== want.travel_dir)
          report_mismatch("travel_dir", int'(out_chan.travel_dir), int'(want.travel_dir));
        if (out_chan.door_opened !== want.door_opened)
          report_mismatch("door_opened", int'(out_chan.door_opened),
                          int'(want.door_opened));
        if (out_chan.pending !== want.pending)
          report_mismatch("pending", int'(out_chan.pending), int'(want.pending));
      end
    end
  end

  // Receiver: runs of ready and stalls of random length, or a forced hold-off
  always @(negedge clk) begin
    if (hold_off > 0) begin
      out_chan.ready = 1'b0;
      hold_off--;
    end else if (steady) begin
      out_chan.ready = 1'b1;
    end else if (rx_ready_left > 0) begin
      out_chan.ready = 1'b1;
      rx_ready_left--;
    end else if (rx_stall_left > 0) begin
      out_chan.ready = 1'b0;
      rx_stall_left--;
    end else begin
      out_chan.ready = 1'b1;
      rx_ready_left = $urandom_range(0, 14);
      rx_stall_left = $urandom_range(1, 5);
    end
  end

  // Watchdog: no beat on either channel for too long
  always @(posedge clk) begin
    if ((in_chan.valid && in_chan.ready) || (out_chan.valid && out_chan.ready)) begin
      quiet_cycles = 0;
    end else begin
      quiet_cycles++;
    end
    if (quiet_cycles >= IDLE_LIMIT) begin
      $display("SCOREBOARD MISMATCH");
      $finish;
    end
  end

  // Tick with nothing pending keeps the car idle at floor 0
  task automatic test_idle_tick();
    send_beat(esc_pkg::KIND_TICK, 4'd9);
  endtask

  // Request at the car's own floor opens the doors at once
  task automatic test_request_at_car();
    send_beat(esc_pkg::KIND_REQ, 4'd0);
  endtask

  // Up sweep with a repeated request; a down request mid-sweep keeps heading,
  // then the emptied up set turns the car down
  task automatic test_up_then_turn_down();
    send_beat(esc_pkg::KIND_REQ, 4'd2);
    send_beat(esc_pkg::KIND_REQ, 4'd2);
    send_beat(esc_pkg::KIND_TICK, 4'd0);
    send_beat(esc_pkg::KIND_TICK, 4'd0);
    send_beat(esc_pkg::KIND_REQ, 4'd0);
    send_beat(esc_pkg::KIND_TICK, 4'd0);
  endtask

  // Down sweep to floor 0, then turn up toward the waiting up request
  task automatic test_down_then_turn_up();
    send_beat(esc_pkg::KIND_REQ, 4'd3);
    send_beat(esc_pkg::KIND_TICK, 4'd0);
    send_beat(esc_pkg::KIND_TICK, 4'd0);
    send_beat(esc_pkg::KIND_TICK, 4'd0);
  endtask

  // Serve the last up request; both sets empty so the car goes idle
  task automatic test_up_to_idle();
    repeat (4) send_beat(esc_pkg::KIND_TICK, 4'd0);
  endtask

  // Idle car with only a down request heads down in the same tick
  task automatic test_idle_picks_down();
    send_beat(esc_pkg::KIND_REQ, 4'd1);
    send_beat(esc_pkg::KIND_TICK, 4'd0);
    send_beat(esc_pkg::KIND_TICK, 4'd0);
    send_beat(esc_pkg::KIND_TICK, 4'd0);
    send_beat(esc_pkg::KIND_TICK, 4'd0);
  endtask

  // Top and bottom floors, with a repeat of the top floor
  task automatic test_far_floors();
    send_beat(esc_pkg::KIND_REQ, 4'd15);
    send_beat(esc_pkg::KIND_REQ, 4'd15);
    send_beat(esc_pkg::KIND_REQ, 4'd0);
    send_beat(esc_pkg::KIND_TICK, 4'd15);
  endtask

  // Mixed ticks and requests; req_pct sets the request share
  task automatic test_random_traffic(input int beats, input int req_pct,
                                     input bit end_floors_only);
    logic                        k;
    logic [esc_pkg::FLOOR_W-1:0] f;
    repeat (beats) begin
      k = ($urandom_range(0, 99) < req_pct) ? esc_pkg::KIND_REQ : esc_pkg::KIND_TICK;
      if (end_floors_only) begin
        f = $urandom_range(0, 1) ? esc_pkg::FLOOR_W'(esc_pkg::FLOOR_CNT - 1) : '0;
      end else begin
        f = esc_pkg::FLOOR_W'($urandom_range(0, esc_pkg::FLOOR_CNT - 1));
      end
      send_beat(k, f);
    end
  endtask

  // Receiver holds off while the sender keeps offering, so the input stalls
  task automatic test_output_backpressure();
    steady = 1'b1;
    hold_off = HOLD_LEN;
    test_random_traffic(24, 40, 1'b0);
    steady = 1'b0;
  endtask

  initial begin
    rst_n          = 1'b0;
    in_chan.valid  = 1'b0;
    in_chan.kind   = esc_pkg::KIND_TICK;
    in_chan.floor  = '0;
    up_reqs        = '0;
    down_reqs      = '0;
    car_pos        = '0;
    car_dir        = esc_pkg::DIR_IDLE;
    repeat (7) @(negedge clk);
    rst_n = 1'b1;

    test_idle_tick();
    test_request_at_car();
    test_up_then_turn_down();
    test_down_then_turn_up();
    test_up_to_idle();
    test_idle_picks_down();
    test_far_floors();

    test_random_traffic(300, 40, 1'b0);
    steady = 1'b1;
    test_random_traffic(150, 25, 1'b0);
    steady = 1'b0;
    test_output_backpressure();
    pause_until_drained();
    test_random_traffic(200, 10, 1'b0);
    test_random_traffic(100, 50, 1'b1);
    pause_until_drained();
    test_random_traffic(150, 30, 1'b0);

    in_chan.valid = 1'b0;
    while (car_status_due.size() != 0) @(posedge clk);
    repeat (8) @(posedge clk);
    if (mismatches == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end

endmodule
